// ===== rtl/mbd_pkg.sv =====
// mbd_pkg: shared types, target codes and reset constants for the memory bank decoder
// depends on nothing; imported by every module under rtl/
package mbd_pkg;

    localparam int unsigned MBD_RAM_WORDS = 65536;
    localparam int unsigned MBD_PADDR_W   = 3;
    localparam int unsigned MBD_PDATA_W   = 32;

    // access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // register indexes (paddr bit 2)
    localparam logic REG_EXROM = 1'b0;
    localparam logic REG_GAME  = 1'b1;

    // target codes
    localparam logic [3:0] TGT_RAM     = 4'd0;
    localparam logic [3:0] TGT_BASIC   = 4'd1;
    localparam logic [3:0] TGT_KERNAL  = 4'd2;
    localparam logic [3:0] TGT_CHARGEN = 4'd3;
    localparam logic [3:0] TGT_VIC     = 4'd4;
    localparam logic [3:0] TGT_SID     = 4'd5;
    localparam logic [3:0] TGT_COLOR   = 4'd6;
    localparam logic [3:0] TGT_CIA1    = 4'd7;
    localparam logic [3:0] TGT_CIA2    = 4'd8;
    localparam logic [3:0] TGT_IO1     = 4'd9;
    localparam logic [3:0] TGT_IO2     = 4'd10;
    localparam logic [3:0] TGT_ROML    = 4'd11;
    localparam logic [3:0] TGT_ROMH    = 4'd12;
    localparam logic [3:0] TGT_ULTIMAX = 4'd13;

    // processor port reset values
    localparam logic [7:0] PORT_DIR_RST     = 8'h2f;
    localparam logic [7:0] PORT_DATA_RST    = 8'h37;
    localparam logic [7:0] PORT_LATCH_RST   = 8'h27;
    localparam logic [7:0] PORT_MIRROR1_RST = 8'h37;
    localparam logic [7:0] PORT_PULLUP_MASK = 8'h17;

    typedef struct packed {
        logic        cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  target;
        logic [12:0] rom_offset;
        logic [7:0]  read_data;
        logic [4:0]  bank_mode;
    } t_out_word;

    typedef struct packed {
        logic [3:0]  target;
        logic [12:0] offset;
        logic        ram_hit;
    } t_dec;

    typedef struct packed {
        logic       dir_we;
        logic       data_we;
        logic [7:0] wdata;
    } t_port_wr;

    typedef struct packed {
        logic exrom_we;
        logic game_we;
        logic value;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0] dir;
        logic [7:0] mirror1;
        logic       exrom;
        logic       game;
        logic [4:0] mode;
        logic [4:0] mode_next;
    } t_port_stat;

endpackage

// ===== rtl/memory_bank_decoder.sv =====
// memory_bank_decoder: top level with bus word pipeline, apb register port and assertions
// depends on mbd_pkg, mbd_decode, mbd_port, mbd_ram
module memory_bank_decoder #(
    parameter int unsigned RAM_WORDS = mbd_pkg::MBD_RAM_WORDS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mbd_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mbd_pkg::t_out_word                 o_out_word,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mbd_pkg::MBD_PADDR_W-1:0]    paddr,
    input  logic [mbd_pkg::MBD_PDATA_W-1:0]    pwdata,
    output logic [mbd_pkg::MBD_PDATA_W-1:0]    prdata,
    output logic                               pready
);
    // Bank decoder for one processor bus word per cycle. Each accepted word
    // (read or write at a 16-bit address) is decoded against the current
    // five-bit bank mode, built from the processor port and the cartridge
    // EXROM/GAME lines, into a target (ram, internal rom, i/o device,
    // cartridge rom or ultimax window) and a rom offset. It takes one word per
    // cycle while the receiver does not stall the output. The single ram port
    // reads in the accept cycle; its registered data holds and is merged into
    // the output register when stage 1 advances. Writes that hit ram
    // (including writes under rom) are stored in the accept cycle, so the
    // following word already sees them. Addresses 0 and 1 are the processor
    // port: writes there update the direction/data registers instead of ram,
    // and reads return the mirror bytes held in flops, so no clearing pass
    // is needed after reset. Ram bytes never written read back undefined.
    // Cartridge lines sit at byte addresses 0 (EXROM) and 4 (GAME) of the
    // register port, bit 0; write them only while no word is in flight.
    import mbd_pkg::*;

    localparam int unsigned RAM_AW = $clog2(RAM_WORDS);

    typedef struct packed {
        logic [3:0]  target;
        logic [12:0] offset;
        logic [4:0]  mode;
        logic        is_load;
        logic        mirror_sel;
        logic [7:0]  mirror_byte;
    } t_stage;

    // handshake
    logic       in_accept;
    logic       out_free;
    logic       s1_adv;
    logic       r_s1_valid, n_s1_valid;
    logic       r_out_valid, n_out_valid;
    t_stage     r_s1;
    t_out_word  r_out;

    // decode and port
    t_dec       dec;
    t_port_wr   port_wr;
    t_cfg_wr    cfg_wr;
    t_port_stat port_stat;
    logic       is_write;
    logic       is_port_addr;
    logic       ram_we;
    logic       ram_re;
    logic [7:0] ram_rdata;
    logic       cfg_write;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign is_write     = (i_in_word.cmd == CMD_WRITE);
    assign is_port_addr = (i_in_word.address[15:1] == 15'd0);

    mbd_decode u_decode (
        .i_mode (port_stat.mode),
        .i_addr (i_in_word.address),
        .i_wr   (is_write),
        .o_dec  (dec)
    );

    // port writes never reach ram; the mirror bytes live in the port block
    assign port_wr.dir_we  = in_accept && is_write && dec.ram_hit && is_port_addr
                             && !i_in_word.address[0];
    assign port_wr.data_we = in_accept && is_write && dec.ram_hit && is_port_addr
                             && i_in_word.address[0];
    assign port_wr.wdata   = i_in_word.write_data;

    // apb: zero wait states, register index from paddr bit 2
    assign cfg_write       = psel && penable && pwrite;
    assign cfg_wr.exrom_we = cfg_write && (paddr[2] == REG_EXROM);
    assign cfg_wr.game_we  = cfg_write && (paddr[2] == REG_GAME);
    assign cfg_wr.value    = pwdata[0];
    assign pready          = 1'b1;
    assign prdata          = {{(MBD_PDATA_W-1){1'b0}},
                              (paddr[2] == REG_GAME) ? port_stat.game : port_stat.exrom};

    mbd_port u_port (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (port_wr),
        .i_cfg   (cfg_wr),
        .o_stat  (port_stat)
    );

    assign ram_we = in_accept && is_write && dec.ram_hit && !is_port_addr;
    assign ram_re = in_accept && !is_write && dec.ram_hit && !is_port_addr;

    mbd_ram #(
        .WORDS (RAM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (i_in_word.address[RAM_AW-1:0]),
        .i_wdata (i_in_word.write_data),
        .o_rdata (ram_rdata)
    );

    // valid flags
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // stage 1: decode results wait for the ram read data
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1.target      <= dec.target;
            r_s1.offset      <= dec.offset;
            r_s1.mode        <= port_stat.mode_next;
            r_s1.is_load     <= dec.ram_hit && !is_write;
            r_s1.mirror_sel  <= is_port_addr;
            r_s1.mirror_byte <= i_in_word.address[0] ? port_stat.mirror1 : port_stat.dir;
        end
    end

    // output register; ram data holds while stage 1 is stalled
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.target     <= r_s1.target;
            r_out.rom_offset <= r_s1.offset;
            r_out.bank_mode  <= r_s1.mode;
            if (!r_s1.is_load) begin
                r_out.read_data <= 8'd0;
            end else if (r_s1.mirror_sel) begin
                r_out.read_data <= r_s1.mirror_byte;
            end else begin
                r_out.read_data <= ram_rdata;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // external targets never carry ram data
    a_ext_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.target != TGT_RAM) |-> (o_out_word.read_data == 8'd0))
        else $error("external target with nonzero read data");

    // a direction write at address 0 reaches the port direction register
    a_dir_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && is_write && (i_in_word.address == 16'd0)
        |=> (port_stat.dir == $past(i_in_word.write_data)))
        else $error("port direction write lost");

    // input is only held off by a full stage 1
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_in_stall)
        else $error("input stalled with empty pipeline");

    // a result never leaves without being decoded in the cycle before
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid))
        else $error("output valid without a stage 1 word");

endmodule

// ===== rtl/mbd_ram.sv =====
// mbd_ram: single-port main ram with registered read data
// depends on mbd_pkg for the default depth
module mbd_ram #(
    parameter int unsigned WORDS = mbd_pkg::MBD_RAM_WORDS
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic                       i_re,
    input  logic [$clog2(WORDS)-1:0]   i_addr,
    input  logic [7:0]                 i_wdata,
    output logic [7:0]                 o_rdata
);
    import mbd_pkg::*;

    logic [7:0] r_mem [WORDS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mbd_port.sv =====
// mbd_port: processor port registers, mirror byte, cartridge lines and bank mode
// depends on mbd_pkg
module mbd_port (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbd_pkg::t_port_wr   i_wr,
    input  mbd_pkg::t_cfg_wr    i_cfg,
    output mbd_pkg::t_port_stat o_stat
);
    import mbd_pkg::*;

    logic [7:0] r_dir, n_dir;
    logic [7:0] r_data, n_data;
    logic [7:0] r_latch, n_latch;
    logic [7:0] r_mirror1, n_mirror1;
    logic       r_exrom, n_exrom;
    logic       r_game, n_game;

    always_comb begin
        n_dir     = i_wr.dir_we  ? i_wr.wdata : r_dir;
        n_data    = i_wr.data_we ? i_wr.wdata : r_data;
        n_latch   = r_latch;
        n_mirror1 = r_mirror1;
        if (i_wr.dir_we || i_wr.data_we) begin
            n_latch   = (r_latch & ~n_dir) | (n_data & n_dir);
            n_mirror1 = (n_data | ~n_dir) & (n_latch | PORT_PULLUP_MASK);
        end
        n_exrom = i_cfg.exrom_we ? i_cfg.value : r_exrom;
        n_game  = i_cfg.game_we  ? i_cfg.value : r_game;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir     <= PORT_DIR_RST;
            r_data    <= PORT_DATA_RST;
            r_latch   <= PORT_LATCH_RST;
            r_mirror1 <= PORT_MIRROR1_RST;
            r_exrom   <= 1'b0;
            r_game    <= 1'b0;
        end else begin
            r_dir     <= n_dir;
            r_data    <= n_data;
            r_latch   <= n_latch;
            r_mirror1 <= n_mirror1;
            r_exrom   <= n_exrom;
            r_game    <= n_game;
        end
    end

    assign o_stat.dir       = r_dir;
    assign o_stat.mirror1   = r_mirror1;
    assign o_stat.exrom     = r_exrom;
    assign o_stat.game      = r_game;
    assign o_stat.mode      = {r_game, r_exrom, (~r_dir[2:0] | r_data[2:0])};
    assign o_stat.mode_next = {r_game, r_exrom, (~n_dir[2:0] | n_data[2:0])};

endmodule

// ===== rtl/mbd_decode.sv =====
// mbd_decode: page decode of one access into target and rom offset
// depends on mbd_pkg
module mbd_decode (
    input  logic [4:0]    i_mode,
    input  logic [15:0]   i_addr,
    input  logic          i_wr,
    output mbd_pkg::t_dec o_dec
);
    import mbd_pkg::*;

    logic       ultimax, exrom, game, lohi, anylohi, hiram, charen;
    logic [7:0] page;
    logic [3:0] io_tgt;
    logic [3:0] tgt;

    assign page    = i_addr[15:8];
    assign ultimax = (i_mode[4:3] == 2'b10);
    assign exrom   = i_mode[3];
    assign game    = i_mode[4];
    assign lohi    = (i_mode[1:0] == 2'b11);
    assign anylohi = (i_mode[1:0] != 2'b00);
    assign hiram   = i_mode[1];
    assign charen  = i_mode[2];

    always_comb begin
        case (page[3:0])
            4'h0, 4'h1, 4'h2, 4'h3: io_tgt = TGT_VIC;
            4'h4, 4'h5, 4'h6, 4'h7: io_tgt = TGT_SID;
            4'h8, 4'h9, 4'ha, 4'hb: io_tgt = TGT_COLOR;
            4'hc:                   io_tgt = TGT_CIA1;
            4'hd:                   io_tgt = TGT_CIA2;
            4'he:                   io_tgt = TGT_IO1;
            default:                io_tgt = TGT_IO2;
        endcase
    end

    always_comb begin
        tgt = TGT_RAM;
        case (page[7:4])
            4'h8, 4'h9: begin
                if (ultimax || (!i_wr && lohi && exrom)) tgt = TGT_ROML;
            end
            4'ha, 4'hb: begin
                if (ultimax) tgt = TGT_ULTIMAX;
                else if (!i_wr && game && exrom && hiram) tgt = TGT_ROMH;
                else if (!i_wr && !game && lohi) tgt = TGT_BASIC;
            end
            4'hd: begin
                if (ultimax || (charen && anylohi)) tgt = io_tgt;
                else if (!i_wr && anylohi) tgt = TGT_CHARGEN;
            end
            4'he, 4'hf: begin
                if (!i_wr && ultimax) tgt = TGT_ROMH;
                else if (!i_wr && hiram) tgt = TGT_KERNAL;
            end
            default: tgt = TGT_RAM;
        endcase
    end

    always_comb begin
        o_dec.target  = tgt;
        o_dec.ram_hit = (tgt == TGT_RAM);
        if (tgt == TGT_RAM) begin
            o_dec.offset = 13'd0;
        end else if (tgt == TGT_CHARGEN) begin
            o_dec.offset = {1'b0, i_addr[11:0]};
        end else begin
            o_dec.offset = i_addr[12:0];
        end
    end

endmodule

// ===== tb/sv/tb_memory_bank_decoder.sv =====
// tb_memory_bank_decoder: self-checking bench for the memory bank decoder top level
// depends on mbd_pkg and memory_bank_decoder; keeps its own image of ram, port and cart lines
module tb_memory_bank_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import mbd_pkg::*;

    localparam int QUIET_LIMIT = 20000;  // cycles with no handshake before giving up
    localparam int TAIL_CYCLES = 20;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_word           i_in_word;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_word          o_out_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [MBD_PADDR_W-1:0] paddr;
    logic [MBD_PDATA_W-1:0] pwdata;
    logic [MBD_PDATA_W-1:0] prdata;
    logic               pready;

    memory_bank_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // mirror of the block state: ram image, which bytes hold defined data, port, cart lines
    logic [7:0]  mem_image [0:MBD_RAM_WORDS-1];
    bit          mem_known [0:MBD_RAM_WORDS-1];
    logic [15:0] known_addrs[$];
    logic [7:0]  port_dir;
    logic [7:0]  port_data;
    logic [7:0]  port_latch;
    logic        exrom_line;
    logic        game_line;

    t_out_word   pending_words[$];   // expected result words, oldest first
    bit          failed;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // current five-bit mode: port bits 2..0, exrom bit 3, game bit 4
    function automatic logic [4:0] bank_mode();
        logic [7:0] lines;
        lines = ~port_dir | port_data;
        return {game_line, exrom_line, lines[2:0]};
    endfunction

    // page map; writes fall through to ram under a rom
    function automatic logic [3:0] route_access(logic [4:0] mode, logic [7:0] page, logic wr);
        logic ultimax;
        logic lohi;
        logic anylohi;
        ultimax = (mode[4:3] == 2'b10);
        lohi    = &mode[1:0];
        anylohi = |mode[1:0];
        if (page >= 8'h80 && page <= 8'h9f) begin
            // roml reads need exrom with loram and hiram; ultimax takes writes too
            if (ultimax || (!wr && lohi && mode[3])) return TGT_ROML;
            return TGT_RAM;
        end
        if (page >= 8'ha0 && page <= 8'hbf) begin
            if (ultimax) return TGT_ULTIMAX;
            if (wr) return TGT_RAM;
            if (mode[4] && mode[3] && mode[1]) return TGT_ROMH;
            if (!mode[4] && lohi) return TGT_BASIC;
            return TGT_RAM;
        end
        if (page >= 8'hd0 && page <= 8'hdf) begin
            // i/o block whenever charen is on with any rom line, and always in ultimax
            if (ultimax || (mode[2] && anylohi)) begin
                case (page[3:0])
                    4'h0, 4'h1, 4'h2, 4'h3: return TGT_VIC;
                    4'h4, 4'h5, 4'h6, 4'h7: return TGT_SID;
                    4'h8, 4'h9, 4'ha, 4'hb: return TGT_COLOR;
                    4'hc: return TGT_CIA1;
                    4'hd: return TGT_CIA2;
                    4'he: return TGT_IO1;
                    default: return TGT_IO2;
                endcase
            end
            if (!wr && anylohi) return TGT_CHARGEN;
            return TGT_RAM;
        end
        if (page >= 8'he0) begin
            if (wr) return TGT_RAM;
            if (ultimax) return TGT_ROMH;
            if (mode[1]) return TGT_KERNAL;
            return TGT_RAM;
        end
        return TGT_RAM;
    endfunction

    // port latch follows the output bits, bytes 0 and 1 mirror the port
    function automatic void refresh_port();
        port_latch   = (port_latch & ~port_dir) | (port_data & port_dir);
        mem_image[0] = port_dir;
        mem_image[1] = (port_data | ~port_dir) & (port_latch | PORT_PULLUP_MASK);
    endfunction

    // expected result of one accepted access, updating the state image
    function automatic t_out_word predict_access(t_in_word w);
        t_out_word r;
        r.target     = route_access(bank_mode(), w.address[15:8], w.cmd == CMD_WRITE);
        r.read_data  = 8'd0;
        if (r.target == TGT_RAM)
            r.rom_offset = 13'd0;
        else if (r.target == TGT_CHARGEN)
            r.rom_offset = {1'b0, w.address[11:0]};
        else
            r.rom_offset = w.address[12:0];
        if (r.target == TGT_RAM) begin
            if (w.cmd == CMD_READ) begin
                r.read_data = mem_image[w.address];
            end else if (w.address == 16'd0) begin
                port_dir = w.write_data;
                refresh_port();
            end else if (w.address == 16'd1) begin
                port_data = w.write_data;
                refresh_port();
            end else begin
                mem_image[w.address] = w.write_data;
                if (!mem_known[w.address]) begin
                    mem_known[w.address] = 1'b1;
                    known_addrs.push_back(w.address);
                end
            end
        end
        r.bank_mode = bank_mode();
        return r;
    endfunction

    // random access, weighted toward the banked regions, port writes and read-backs
    function automatic t_in_word random_access();
        t_in_word    w;
        int unsigned pick;
        w.cmd        = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        w.write_data = 8'($urandom);
        pick         = $urandom_range(99);
        if (pick < 8) begin
            w.cmd     = CMD_WRITE;
            w.address = 16'($urandom_range(1));
        end else if (pick < 36) begin
            w.cmd     = CMD_READ;
            w.address = known_addrs[$urandom_range(known_addrs.size() - 1)];
        end else if (pick < 44) begin
            w.address = 16'($urandom_range(16'h00ff));
        end else if (pick < 56) begin
            w.address = 16'h8000 + 16'($urandom_range(16'h1fff));
        end else if (pick < 66) begin
            w.address = 16'ha000 + 16'($urandom_range(16'h1fff));
        end else if (pick < 80) begin
            w.address = 16'hd000 + 16'($urandom_range(16'h0fff));
        end else if (pick < 90) begin
            w.address = 16'he000 + 16'($urandom_range(16'h1fff));
        end else begin
            w.address = 16'($urandom);
        end
        return w;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endfunction

    // predict on every accepted access word, check every accepted result word
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                pending_words.push_back(predict_access(i_in_word));
            if (o_out_valid && !i_out_stall) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, o_out_word);
                    failed = 1'b1;
                end else begin
                    exp_w = pending_words.pop_front();
                    check_field("target", 32'(exp_w.target), 32'(o_out_word.target));
                    check_field("rom_offset", 32'(exp_w.rom_offset),
                                32'(o_out_word.rom_offset));
                    check_field("read_data", 32'(exp_w.read_data), 32'(o_out_word.read_data));
                    check_field("bank_mode", 32'(exp_w.bank_mode), 32'(o_out_word.bank_mode));
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);

    // watchdog: count cycles with no handshake on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // send one access word; called at a falling edge, returns at the falling edge after
    // acceptance with valid still high so back-to-back words need no extra edge
    task automatic send_word(input t_in_word w);
        // never read a ram byte that holds no defined data
        if (w.cmd == CMD_READ && !mem_known[w.address]
                && route_access(bank_mode(), w.address[15:8], 1'b0) == TGT_RAM)
            w.address = known_addrs[$urandom_range(known_addrs.size() - 1)];
        if ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_access(input logic cmd, input logic [15:0] addr, input logic [7:0] data);
        t_in_word w;
        w.cmd        = cmd;
        w.address    = addr;
        w.write_data = data;
        send_word(w);
    endtask

    task automatic idle_input();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        while (pending_words.size() != 0) @(negedge i_clk);
    endtask

    // one apb transfer: setup, access, then an idle gap with psel low before the next one
    task automatic apb_access(input logic wr, input logic reg_sel, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // set both cartridge lines while idle and read them back
    task automatic set_cart(input logic exrom, input logic game);
        logic [31:0] rd;
        apb_access(1'b1, REG_EXROM, {31'd0, exrom}, rd);
        apb_access(1'b1, REG_GAME, {31'd0, game}, rd);
        exrom_line = exrom;
        game_line  = game;
        apb_access(1'b0, REG_EXROM, 32'd0, rd);
        if (rd[0] !== exrom) begin
            $display("%0t: exrom readback, expected %0d, actual %0d", $time, exrom, rd[0]);
            failed = 1'b1;
        end
        apb_access(1'b0, REG_GAME, 32'd0, rd);
        if (rd[0] !== game) begin
            $display("%0t: game readback, expected %0d, actual %0d", $time, game, rd[0]);
            failed = 1'b1;
        end
    endtask

    task automatic random_phase(input logic exrom, input logic game, input int n);
        set_cart(exrom, game);
        repeat (n) send_word(random_access());
        idle_input();
        wait_drain();
    endtask

    // directed walk of the page map in the reset configuration, then port writes
    task automatic test_page_map();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_access(CMD_READ,  16'h0000, 8'h00);   // port mirror bytes after reset
        send_access(CMD_READ,  16'h0001, 8'h00);
        send_access(CMD_WRITE, 16'h0002, 8'h00);
        send_access(CMD_READ,  16'h0002, 8'h00);
        send_access(CMD_WRITE, 16'hffff, 8'hff);   // write under kernal lands in ram
        send_access(CMD_READ,  16'hffff, 8'h00);
        send_access(CMD_WRITE, 16'ha000, 8'h5a);   // write under basic
        send_access(CMD_READ,  16'ha000, 8'h00);
        send_access(CMD_WRITE, 16'h8000, 8'h81);
        send_access(CMD_READ,  16'h8000, 8'h00);
        send_access(CMD_READ,  16'hd000, 8'h00);   // each i/o device
        send_access(CMD_READ,  16'hd7ff, 8'h00);
        send_access(CMD_WRITE, 16'hd800, 8'h0f);
        send_access(CMD_READ,  16'hdc00, 8'h00);
        send_access(CMD_READ,  16'hdd00, 8'h00);
        send_access(CMD_READ,  16'hde00, 8'h00);
        send_access(CMD_WRITE, 16'hdfff, 8'h00);
        send_access(CMD_WRITE, 16'h0001, 8'h33);   // charen off: chargen window
        send_access(CMD_READ,  16'hd123, 8'h00);
        send_access(CMD_WRITE, 16'h0000, 8'hff);   // all port bits driven
        send_access(CMD_WRITE, 16'h0001, 8'h00);   // all roms out
        send_access(CMD_WRITE, 16'hd000, 8'h11);
        send_access(CMD_READ,  16'hd000, 8'h00);
        send_access(CMD_READ,  16'ha000, 8'h00);
        send_access(CMD_WRITE, 16'h0000, PORT_DIR_RST);
        send_access(CMD_WRITE, 16'h0001, PORT_DATA_RST);
        idle_input();
        wait_drain();
    endtask

    task automatic test_full_rate();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        random_phase(1'b0, 1'b0, 128);
        random_phase(1'b1, 1'b1, 128);
    endtask

    task automatic test_sender_gaps();
        src_idle_pct   = 56;
        sink_stall_pct = 0;
        random_phase(1'b1, 1'b0, 128);
        random_phase(1'b0, 1'b1, 128);
    endtask

    task automatic test_receiver_stalls();
        src_idle_pct   = 0;
        sink_stall_pct = 56;
        random_phase(1'b0, 1'b1, 128);
        random_phase(1'b1, 1'b1, 128);
    endtask

    task automatic test_light_idle();
        src_idle_pct   = 11;
        sink_stall_pct = 11;
        random_phase(1'b1, 1'b0, 128);
        random_phase(1'b0, 1'b0, 128);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_word      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        failed         = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        quiet_cycles   = 0;
        // state image after reset: only the two port mirror bytes are defined
        port_dir       = PORT_DIR_RST;
        port_data      = PORT_DATA_RST;
        port_latch     = PORT_LATCH_RST;
        exrom_line     = 1'b0;
        game_line      = 1'b0;
        mem_image[0]   = PORT_DIR_RST;
        mem_image[1]   = PORT_MIRROR1_RST;
        mem_known[0]   = 1'b1;
        mem_known[1]   = 1'b1;
        known_addrs.push_back(16'd0);
        known_addrs.push_back(16'd1);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_page_map();
        test_full_rate();
        test_sender_gaps();
        test_receiver_stalls();
        test_light_idle();

        // let any stray result words show up before the verdict
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (!failed && pending_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
